// ===== rtl/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared sizes, codes and types of the two-level page table
// ----------------------------------------------------------------------------
package tlpt_pkg;

   // table geometry
   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int SLOTS         = DIR_ENTRIES * TABLE_ENTRIES;
   localparam int DIR_W         = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int SLOT_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // virtual address split
   localparam int OFFSET_W = 12;
   localparam int IDX_W    = 10;
   localparam int FRAME_W  = 32 - OFFSET_W;

   // stream widths
   localparam int REQ_TDATA_W = 80;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [1:0] {
      FUNC_TRANSLATE = 2'd0,
      FUNC_MAP       = 2'd1,
      FUNC_UNMAP     = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_FAULT  = 2'd1,
      STAT_MAPPED = 2'd2
   } status_type;

   // what the back end has to do with a request
   typedef enum logic [1:0] {
      OP_TRANSLATE,
      OP_MAP,
      OP_UNMAP,
      OP_FAULT
   } op_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

   // classified request as held in the queue
   typedef struct packed {
      op_type                op;
      logic [DIR_W-1:0]      dir;
      logic [SLOT_W-1:0]     slot;
      logic [OFFSET_W-1:0]   offset;
      logic [31:0]           entry_new;
      logic                  misaligned;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

// ===== rtl/tlpt_queue.sv =====
// ----------------------------------------------------------------------------
// tlpt_queue
// two-entry queue of classified requests between front and back end
// ----------------------------------------------------------------------------
module tlpt_queue
   import tlpt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

// ===== rtl/tlpt_front.sv =====
// ----------------------------------------------------------------------------
// tlpt_front
// request intake: splits the address, range-checks it and classifies the item
// ----------------------------------------------------------------------------
module tlpt_front
   import tlpt_pkg::*;
(
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TUSER_W-1:0] req_func,
   input  logic [31:0]            req_vaddr,
   input  logic [31:0]            req_paddr,
   input  logic [OFFSET_W-1:0]    req_flags,
   input  queue_status_type       queue_status,
   input  logic                   clearing,
   output logic                   push,
   output cmd_type                push_cmd
);

   logic [IDX_W-1:0] dir_idx;
   logic [IDX_W-1:0] tbl_idx;
   logic             in_range;
   logic [31:0]      slot_full;
   logic             mis;

   assign dir_idx   = req_vaddr[31:32-IDX_W];
   assign tbl_idx   = req_vaddr[31-IDX_W:OFFSET_W];
   assign in_range  = (32'(dir_idx) < 32'(DIR_ENTRIES)) &&
                      (32'(tbl_idx) < 32'(TABLE_ENTRIES));
   assign slot_full = 32'(dir_idx) * 32'(TABLE_ENTRIES) + 32'(tbl_idx);
   assign mis       = (req_paddr[OFFSET_W-1:0] != '0);

   assign req_tready = !queue_status.full && !clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_cmd.dir        = dir_idx[DIR_W-1:0];
      push_cmd.slot       = slot_full[SLOT_W-1:0];
      push_cmd.offset     = req_vaddr[OFFSET_W-1:0];
      push_cmd.entry_new  = {req_paddr[31:OFFSET_W], req_flags | OFFSET_W'(1)};
      push_cmd.misaligned = 1'b0;
      unique case (func_type'(req_func))
         FUNC_TRANSLATE: push_cmd.op = in_range ? OP_TRANSLATE : OP_FAULT;
         FUNC_MAP: begin
            push_cmd.op         = in_range ? OP_MAP : OP_FAULT;
            push_cmd.misaligned = mis;
         end
         FUNC_UNMAP:     push_cmd.op = in_range ? OP_UNMAP : OP_FAULT;
         default:        push_cmd.op = OP_FAULT;
      endcase
   end

endmodule

// ===== rtl/tlpt_back.sv =====
// ----------------------------------------------------------------------------
// tlpt_back
// execution: clearing pass, directory and entry lookup, write-back, result
// ----------------------------------------------------------------------------
module tlpt_back
   import tlpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  queue_status_type       queue_status,
   input  cmd_type                head_cmd,
   output logic                   pop,
   output logic                   clearing,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic [SLOT_W:0]   DIR_LIMIT  = (SLOT_W + 1)'(DIR_ENTRIES);
   localparam logic [SLOT_W-1:0] CLEAR_LAST = SLOT_W'(SLOTS - 1);

   logic [31:0]     entry_mem_ff [SLOTS];
   logic            dir_mem_ff   [DIR_ENTRIES];

   back_state_type      state_ff, state_in;
   logic [SLOT_W-1:0]   clear_cnt_ff, clear_cnt_in;
   cmd_type             cmd_ff;
   logic [31:0]         entry_rd_ff;
   logic                dir_rd_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic                out_free;
   logic                rd_en;
   logic                commit;
   logic                entry_we;
   logic [SLOT_W-1:0]   entry_waddr;
   logic [31:0]         entry_wdata;
   logic                dir_we;
   logic [DIR_W-1:0]    dir_waddr;
   logic                dir_wdata;
   status_type          status;
   logic [31:0]         phys;
   logic                present;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign present  = dir_rd_ff && entry_rd_ff[0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clear_cnt_ff == CLEAR_LAST) state_in = BK_IDLE;
         BK_IDLE:  if (!queue_status.empty) state_in = BK_EXEC;
         BK_EXEC:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // control outputs
   always_comb begin
      clearing = 1'b0;
      pop      = 1'b0;
      rd_en    = 1'b0;
      commit   = 1'b0;
      unique case (state_ff)
         BK_CLEAR: clearing = 1'b1;
         BK_IDLE: begin
            pop   = !queue_status.empty;
            rd_en = !queue_status.empty;
         end
         BK_EXEC:  commit = out_free;
         default:  clearing = 1'b1;
      endcase
   end

   // result and write-back of the item in execution
   always_comb begin
      status      = STAT_FAULT;
      phys        = '0;
      entry_we    = 1'b0;
      entry_waddr = cmd_ff.slot;
      entry_wdata = '0;
      dir_we      = 1'b0;
      dir_waddr   = cmd_ff.dir;
      dir_wdata   = 1'b1;
      unique case (cmd_ff.op)
         OP_TRANSLATE: if (present) begin
            status = STAT_OK;
            phys   = {entry_rd_ff[31:OFFSET_W], cmd_ff.offset};
         end
         OP_MAP: begin
            dir_we = commit;
            if (entry_rd_ff[0]) begin
               status = STAT_MAPPED;
            end else begin
               status      = STAT_OK;
               entry_we    = commit;
               entry_wdata = cmd_ff.entry_new;
            end
         end
         OP_UNMAP: if (present) begin
            status   = STAT_OK;
            entry_we = commit;
         end
         default: status = STAT_FAULT;
      endcase
      // clearing pass zeroes one entry a cycle, directory bits on the way
      if (clearing) begin
         entry_we    = 1'b1;
         entry_waddr = clear_cnt_ff;
         entry_wdata = '0;
         dir_we      = ({1'b0, clear_cnt_ff} < DIR_LIMIT);
         dir_waddr   = clear_cnt_ff[DIR_W-1:0];
         dir_wdata   = 1'b0;
      end
   end

   assign clear_cnt_in = clearing ? clear_cnt_ff + SLOT_W'(1) : clear_cnt_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
      if (commit) begin
         rsp_data_ff <= {(RSP_TDATA_W - 35)'(0), cmd_ff.misaligned, phys, status};
      end
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem_ff[entry_waddr] <= entry_wdata;
      end
      if (rd_en) begin
         entry_rd_ff <= entry_mem_ff[head_cmd.slot];
      end
   end

   // directory memory
   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem_ff[dir_waddr] <= dir_wdata;
      end
      if (rd_en) begin
         dir_rd_ff <= dir_mem_ff[head_cmd.dir];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/two_level_page_table_top.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_top
// two-level page table: translate, map and unmap over a 32-bit address space
// ----------------------------------------------------------------------------
// path: queue slot, then the memory read registers, then the result register behind rsp_tvalid
// pace: one item at a time in the back end, set by the read-then-write pass of the
//    back end over the directory and entry memories
// reset: synchronous; then a clearing pass zeroes all DIR_ENTRIES*TABLE_ENTRIES
//    (1048576) entries and the directory bits, with req_tready low the whole time
// ----------------------------------------------------------------------------
module two_level_page_table_top
   import tlpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // vaddr[31:0], paddr[63:32], flags[75:64]
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // func[1:0]
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // status[1:0], phys_addr[33:2], misaligned[34]
);

   // front to queue
   logic             push;
   cmd_type          push_cmd;

   // queue to back end
   cmd_type          head_cmd;
   queue_status_type queue_status;
   logic             pop;

   // back end busy with its clearing pass after reset
   logic             clearing;

   // intake: field unpacking, address split, range check and classification
   tlpt_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_func     (req_tuser),
      .req_vaddr    (req_tdata[31:0]),
      .req_paddr    (req_tdata[63:32]),
      .req_flags    (req_tdata[75:64]),
      .queue_status (queue_status),
      .clearing     (clearing),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   // decouples intake from execution so either side can stall alone
   tlpt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   // execution: memory lookup, update and the registered result item
   tlpt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .clearing     (clearing),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-level page table: a directed table of
// requests, then random map, translate and unmap traffic over a small pool
// of pages, each result checked against a typed value or a page-walk predictor
// ----------------------------------------------------------------------------
module tb_top;
   import tlpt_pkg::*;

   // 2-bit code that the func field can carry but that names no operation
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 852;
   localparam int PHASES       = 4;
   localparam int POOL_SIZE    = 24;
   localparam int DRAIN_CYCLES = 8;
   // cycles with no item moving on either channel before the run is abandoned;
   // the clearing pass after reset holds req_tready low, so a longer limit applies until the first request is taken
   localparam int STALL_LIMIT  = 5000;
   localparam int CLEAR_LIMIT  = 4 * SLOTS;

   typedef struct {
      logic [1:0]  func;
      logic [31:0] vaddr;
      logic [31:0] paddr;
      logic [11:0] flags;
   } page_req_type;

   typedef struct {
      status_type  status;
      logic [31:0] phys;
      logic        mis;
   } page_rsp_type;

   // one row of the directed table; the result is typed in where obvious
   typedef struct {
      page_req_type req;
      bit           typed;
      page_rsp_type rsp;
   } directed_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // vaddr[31:0], paddr[63:32], flags[75:64]
   logic [REQ_TUSER_W-1:0] req_tuser = '0;  // func[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;       // status[1:0], phys_addr[33:2], misaligned[34]

   // predictor state: directory present bits and the written entries only
   bit [DIR_ENTRIES-1:0]  dir_mapped;
   logic [31:0]           page_store [int unsigned];

   page_rsp_type     pending_results [$];
   directed_row_type directed_rows [$];

   int errors        = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_cycles   = 0;
   bit started       = 1'b0;

   // coverage tallies, taken from the results as they are checked
   int n_results    = 0;
   int n_hits       = 0;
   int n_faults     = 0;
   int n_remaps     = 0;
   int n_misaligned = 0;

   two_level_page_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // walk the table for one accepted request and apply its side effects
   function automatic page_rsp_type walk_page_table(input page_req_type rq);
      logic [9:0]   di;
      logic [9:0]   ti;
      bit           in_range;
      int unsigned  slot;
      logic [31:0]  entry;
      page_rsp_type r;
      di       = rq.vaddr[31:22];
      ti       = rq.vaddr[21:12];
      in_range = (int'(di) < DIR_ENTRIES) && (int'(ti) < TABLE_ENTRIES);
      slot     = in_range ? int'(di) * TABLE_ENTRIES + int'(ti) : 0;
      entry    = page_store.exists(slot) ? page_store[slot] : 32'h0;
      r.status = STAT_FAULT;
      r.phys   = 32'h0;
      r.mis    = 1'b0;
      case (rq.func)
         FUNC_TRANSLATE: begin
            // both levels must be present; offset rides on the frame
            if (in_range && dir_mapped[di] && entry[0]) begin
               r.status = STAT_OK;
               r.phys   = {entry[31:12], 12'h000} + {20'h0, rq.vaddr[11:0]};
            end
         end
         FUNC_MAP: begin
            r.mis = |rq.paddr[11:0];
            if (in_range) begin
               // directory is marked even when the entry is already taken
               dir_mapped[di] = 1'b1;
               if (entry[0]) begin
                  r.status = STAT_MAPPED;
               end else begin
                  page_store[slot] = {rq.paddr[31:12], 12'h000} | {20'h0, rq.flags} | 32'h1;
                  r.status         = STAT_OK;
               end
            end
         end
         FUNC_UNMAP: begin
            if (in_range && dir_mapped[di] && entry[0]) begin
               page_store.delete(slot);
               r.status = STAT_OK;
            end
         end
         default: ;  // reserved code: fault, no change
      endcase
      return r;
   endfunction

   task automatic add_row(input logic [1:0] func, input logic [31:0] vaddr,
                          input logic [31:0] paddr, input logic [11:0] flags,
                          input bit typed, input status_type status,
                          input logic [31:0] phys, input logic mis);
      directed_row_type row;
      row.req   = '{func, vaddr, paddr, flags};
      row.typed = typed;
      row.rsp   = '{status, phys, mis};
      directed_rows.push_back(row);
   endtask

   // present one item from a falling edge until it is taken; returns at a falling edge
   task automatic drive_item(input page_req_type rq, input bit typed,
                             input page_rsp_type typed_rsp);
      page_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, rq.flags, rq.paddr, rq.vaddr};
      req_tuser  <= rq.func;
      do @(posedge clock); while (!req_tready);
      // accepted at this edge: the predictor state moves in acceptance order
      predicted = walk_page_table(rq);
      pending_results.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic wait_results_drained;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver: stall at random at the configured rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker: each item against the oldest expectation
   always @(posedge clock) begin
      page_rsp_type want;
      status_type   got_status;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = status_type'(rsp_tdata[1:0]);
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result: status %0d phys_addr %h misaligned %0b",
                     $time, rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[34]);
         end else begin
            want = pending_results.pop_front();
            n_results++;
            if (want.status == STAT_OK && want.phys != 32'h0) n_hits++;
            if (want.status == STAT_FAULT) n_faults++;
            if (want.status == STAT_MAPPED) n_remaps++;
            if (want.mis) n_misaligned++;
            if (got_status != want.status) begin
               errors++;
               $display("%0t status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_tdata[1:0]);
            end
            if (rsp_tdata[33:2] != want.phys) begin
               errors++;
               $display("%0t phys_addr mismatch: expected %h actual %h",
                        $time, want.phys, rsp_tdata[33:2]);
            end
            if (rsp_tdata[34] != want.mis) begin
               errors++;
               $display("%0t misaligned mismatch: expected %0b actual %0b",
                        $time, want.mis, rsp_tdata[34]);
            end
         end
      end
   end

   // watchdog: cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
         if (req_tvalid && req_tready) started <= 1'b1;
      end else if (idle_cycles >= (started ? STALL_LIMIT : CLEAR_LIMIT)) begin
         $display("%0t watchdog: no item moved for %0d cycles", $time, idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      page_req_type rq;
      page_rsp_type none;
      logic [19:0]  page_pool [POOL_SIZE];
      logic [9:0]   dir_pick [4];
      int           r;
      int           phase_idle [PHASES];
      int           phase_stall [PHASES];
      none = '{STAT_FAULT, 32'h0, 1'b0};
      // idling phases: none, sender only, receiver only, both lightly
      phase_idle  = '{0, 54, 0, 13};
      phase_stall = '{0, 0, 54, 13};

      // directed: empty table first, then the extremes of address and frame
      add_row(FUNC_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      add_row(FUNC_UNMAP,     32'h1234_5678, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      // reserved func with every other bit set
      add_row(FUNC_RESERVED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF,
              1, STAT_FAULT, 32'h0, 1'b0);
      add_row(FUNC_MAP,       32'h0000_0000, 32'h0000_0000, 12'h000, 1, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'h0000_0FFF, 32'h0, 12'h000, 1, STAT_OK, 32'h0000_0FFF, 1'b0);
      add_row(FUNC_MAP,       32'hFFFF_FFFF, 32'hFFFF_F000, 12'hFFF, 1, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'hFFFF_F000, 32'h0, 12'h000, 1, STAT_OK, 32'hFFFF_F000, 1'b0);
      add_row(FUNC_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 12'h000, 1, STAT_OK, 32'hFFFF_FFFF, 1'b0);
      // entry taken: already mapped, misaligned still flagged
      add_row(FUNC_MAP,       32'hFFFF_F123, 32'h1234_5FFF, 12'h555,
              1, STAT_MAPPED, 32'h0, 1'b1);
      // misaligned map still goes through with the low bits dropped
      add_row(FUNC_MAP,       32'h0040_1000, 32'hABCD_E001, 12'h0AA, 1, STAT_OK, 32'h0, 1'b1);
      add_row(FUNC_TRANSLATE, 32'h0040_1ABC, 32'h0, 12'h000, 1, STAT_OK, 32'hABCD_EABC, 1'b0);
      // directory present, entry missing
      add_row(FUNC_TRANSLATE, 32'h0040_2000, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      add_row(FUNC_UNMAP,     32'h0040_1000, 32'h0, 12'h000, 1, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'h0040_1000, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      add_row(FUNC_UNMAP,     32'h0040_1000, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      // these rows go through the predictor
      add_row(FUNC_MAP,       32'h0040_1FFF, 32'h8000_0000, 12'h001, 0, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'h0040_1555, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_UNMAP,     32'hFFFF_FFFF, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'hFFFF_FABC, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_MAP,       32'h7FFF_F000, 32'h7FFF_F7FF, 12'h800, 0, STAT_OK, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'h7FFF_F800, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 1'b0);
      // reserved func on a mapped page changes nothing
      add_row(FUNC_RESERVED,  32'h0000_0000, 32'h0, 12'h000, 1, STAT_FAULT, 32'h0, 1'b0);
      add_row(FUNC_TRANSLATE, 32'h0000_0000, 32'h0, 12'h000, 0, STAT_OK, 32'h0, 1'b0);

      // reset, then the block runs its clearing pass with req_tready low
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         drive_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end
      req_tvalid <= 1'b0;
      wait_results_drained();

      // random traffic, one idling phase after another
      for (int ph = 0; ph < PHASES; ph++) begin
         @(negedge clock);
         send_idle_pct = phase_idle[ph];
         stall_pct     = phase_stall[ph];
         // a few directories, many pages: hits, misses and remaps all occur
         foreach (dir_pick[k]) dir_pick[k] = 10'($urandom);
         foreach (page_pool[k]) page_pool[k] = {dir_pick[$urandom_range(3)], 10'($urandom)};
         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            r = $urandom_range(99);
            if (r < 40)      rq.func = FUNC_TRANSLATE;
            else if (r < 70) rq.func = FUNC_MAP;
            else if (r < 95) rq.func = FUNC_UNMAP;
            else             rq.func = FUNC_RESERVED;
            if ($urandom_range(99) < 85)
               rq.vaddr = {page_pool[$urandom_range(POOL_SIZE - 1)], 12'($urandom)};
            else
               rq.vaddr = $urandom;
            rq.paddr = $urandom;
            // half the frames aligned so both misaligned values show up
            if ($urandom_range(1) == 0) rq.paddr[11:0] = 12'h000;
            rq.flags = 12'($urandom);
            drive_item(rq, 1'b0, none);
         end
         req_tvalid <= 1'b0;
         // sender holds off until every outstanding result is back
         wait_results_drained();
      end

      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         errors++;
         $display("%0t %0d results never arrived", $time, pending_results.size());
      end

      $display("run covered %0d requests over four idling phases after the clearing pass",
               n_results);
      $display("results: %0d translation hits, %0d faults, %0d already mapped, %0d misaligned",
               n_hits, n_faults, n_remaps, n_misaligned);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
